// ----- design/tcd_pkg.sv -----
`default_nettype none

package tcd_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_SETPOINT       = 3'd0;
   localparam logic [2:0] REG_DWELL_MS       = 3'd1;
   localparam logic [2:0] REG_COOL_BAND      = 3'd2;
   localparam logic [2:0] REG_HEAT_BAND      = 3'd3;
   localparam logic [2:0] REG_HEATER_FAMILY  = 3'd4;
   localparam logic [2:0] REG_CHAMBER_FAMILY = 3'd5;

   // sensor family codes
   localparam logic [7:0] FAMILY_SHIFTED  = 8'h10;
   localparam logic [7:0] FAMILY_MASKED_A = 8'h28;
   localparam logic [7:0] FAMILY_MASKED_B = 8'h22;

   // resolution field codes, bits 6:5 of the config byte
   localparam logic [1:0] RES_9BIT  = 2'b00;
   localparam logic [1:0] RES_10BIT = 2'b01;
   localparam logic [1:0] RES_11BIT = 2'b10;
   localparam logic [1:0] RES_12BIT = 2'b11;

   // count-remain refinement
   localparam logic [7:0]  COUNT_PER_DEGREE_FULL = 8'h10;
   localparam logic [15:0] REMAIN_BIAS           = 16'd12;

   // reset values
   localparam logic signed [11:0] SETPOINT_RESET  = -12'sd320;
   localparam logic [31:0]        DWELL_RESET     = 32'd300000;
   localparam logic [7:0]         COOL_BAND_RESET = 8'd16;
   localparam logic [7:0]         HEAT_BAND_RESET = 8'd32;
   localparam logic [7:0]         FAMILY_RESET    = FAMILY_MASKED_A;

   typedef struct packed {
      logic signed [11:0] setpoint;
      logic [31:0]        dwell_ms;
      logic [7:0]         cool_band;
      logic [7:0]         heat_band;
      logic [7:0]         heater_family;
      logic [7:0]         chamber_family;
   } cfg_type;

   typedef struct packed {
      logic [7:0] lsb;
      logic [7:0] msb;
      logic [7:0] res_cfg;
      logic [7:0] remain;
      logic [7:0] per_degree;
   } sensor_raw_type;

   typedef struct packed {
      logic        heat_on;
      logic        cool_on;
      logic        read_error;
      logic [31:0] since_switch_ms;
   } decision_type;

endpackage

`default_nettype wire

// ----- design/tcd_conv.sv -----
`default_nettype none

module tcd_conv
   import tcd_pkg::*;
(
   input  wire logic [7:0]         family,
   input  wire sensor_raw_type     raw_in,
   output logic signed [15:0]      temp,
   output logic                    ok
);

   logic [15:0] raw;
   logic [15:0] shifted;
   logic [15:0] refined;

   assign raw     = {raw_in.msb, raw_in.lsb};
   assign shifted = {raw[12:0], 3'b000};
   assign refined = {shifted[15:4], 4'b0000} + REMAIN_BIAS - {8'b0, raw_in.remain};

   always_comb begin
      temp = '0;
      ok   = 1'b1;
      if (family == FAMILY_SHIFTED) begin
         if (raw_in.per_degree == COUNT_PER_DEGREE_FULL) begin
            temp = refined;
         end else begin
            temp = shifted;
         end
      end else if (family == FAMILY_MASKED_A || family == FAMILY_MASKED_B) begin
         case (raw_in.res_cfg[6:5])
            RES_9BIT:  temp = {raw[15:3], 3'b000};
            RES_10BIT: temp = {raw[15:2], 2'b00};
            RES_11BIT: temp = {raw[15:1], 1'b0};
            default:   temp = raw;
         endcase
      end else begin
         ok = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- design/tcd_ctrl.sv -----
`default_nettype none

module tcd_ctrl
   import tcd_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic               setpoint_write,
   input  wire cfg_type            cfg,
   input  wire logic [31:0]        time_ms,
   input  wire logic signed [15:0] heater_temp,
   input  wire logic signed [15:0] chamber_temp,
   input  wire logic               heater_ok,
   input  wire logic               chamber_ok,
   output decision_type            dec
);

   localparam int WIDE_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

   logic                 cooling_ff, cooling_in;
   logic                 heating_ff, heating_in;
   logic                 first_ff, first_in;
   logic [TIME_BITS-1:0] last_switch_ff, last_switch_in;

   logic [TIME_BITS-1:0] now;
   logic [TIME_BITS-1:0] elapsed;
   logic                 err;
   logic                 may_switch;
   logic                 want_cool;
   logic                 do_switch;
   logic signed [17:0]   sp_wide;
   logic signed [17:0]   ht_wide;
   logic signed [17:0]   ct_wide;
   logic signed [17:0]   cool_limit;
   logic signed [17:0]   heat_limit;

   assign now     = TIME_BITS'(time_ms);
   assign elapsed = now - last_switch_ff;
   assign err     = !(heater_ok && chamber_ok);

   assign sp_wide    = 18'(cfg.setpoint);
   assign ht_wide    = 18'(heater_temp);
   assign ct_wide    = 18'(chamber_temp);
   assign cool_limit = sp_wide + $signed({10'b0, cfg.cool_band});
   assign heat_limit = sp_wide + $signed({10'b0, cfg.heat_band});

   assign may_switch = first_ff || (WIDE_BITS'(elapsed) > WIDE_BITS'(cfg.dwell_ms));
   assign want_cool  = ct_wide > cool_limit;
   assign do_switch  = !err && may_switch && (want_cool != cooling_ff);

   always_comb begin
      cooling_in     = cooling_ff;
      heating_in     = heating_ff;
      last_switch_in = last_switch_ff;
      first_in       = first_ff;
      if (do_switch) begin
         cooling_in     = want_cool;
         last_switch_in = now;
         first_in       = 1'b0;
      end
      if (!err) begin
         if (!cooling_in) begin
            heating_in = sp_wide > ht_wide;
         end else begin
            heating_in = (sp_wide > ct_wide) && (heat_limit > ht_wide);
         end
      end
   end

   // cooler and heater flags show the state after this step
   assign dec.heat_on         = heating_in;
   assign dec.cool_on         = cooling_in;
   assign dec.read_error      = err;
   assign dec.since_switch_ms = 32'(elapsed);

   always_ff @(posedge clock) begin
      if (reset) begin
         cooling_ff     <= 1'b0;
         heating_ff     <= 1'b0;
         first_ff       <= 1'b1;
         last_switch_ff <= '0;
      end else begin
         if (step) begin
            cooling_ff     <= cooling_in;
            heating_ff     <= heating_in;
            last_switch_ff <= last_switch_in;
         end
         if (setpoint_write) begin
            first_ff <= 1'b1;
         end else if (step) begin
            first_ff <= first_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_err_holds_cooler: assert property (@(posedge clock) disable iff (reset)
      (step && err) |=> (cooling_ff == $past(cooling_ff)) && (heating_ff == $past(heating_ff)))
      else $error("cooler or heater changed on a read error");

   a_switch_stamps_time: assert property (@(posedge clock) disable iff (reset)
      (step && do_switch) |=> (last_switch_ff == $past(now)))
      else $error("cooler switch did not record its time");

   a_no_switch_no_stamp: assert property (@(posedge clock) disable iff (reset)
      (step && !do_switch) |=> $stable(last_switch_ff) && $stable(cooling_ff))
      else $error("switch state moved without a switch");
`endif

endmodule

`default_nettype wire

// ----- design/thermostat_with_cooling_dwell_top.sv -----
`default_nettype none

// channel   dir  handshake                word contents (low bit first)
// req_*     in   req_tvalid/req_tready    time_ms, heater lsb..per_degree, chamber lsb..per_degree
// rsp_*     out  rsp_tvalid/rsp_tready    tdata: temps, since_switch_ms; tuser: flags
// csr_*     in   psel/penable (apb)       setpoint, dwell_ms, bands, family codes
//
// one word per cycle while rsp_tready is high: input register, conversion and decision logic, result register
// an accepted word goes from the input register to the result register; rsp_tvalid stays high until rsp_tready takes it
// reset is synchronous; cooler and heater off, first decision armed, last switch time zero
// a stalled rsp holds its word while the input register still takes one more word
// csr writes are expected only while no word is in flight

module thermostat_with_cooling_dwell_top
   import tcd_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,

   input  wire logic          req_tvalid,
   output logic               req_tready,
   // time_ms[31:0], heater lsb, msb, res_cfg, remain, per_degree,
   // chamber lsb, msb, res_cfg, remain, per_degree
   input  wire logic [111:0]  req_tdata,

   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // heater_temp[15:0], chamber_temp[31:16], since_switch_ms[63:32]
   output logic [63:0]        rsp_tdata,
   // heat_on[0], cool_on[1], read_error[2]
   output logic [2:0]         rsp_tuser,

   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [4:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // configuration registers
   cfg_type cfg_ff, cfg_in;
   logic    csr_write;
   logic    setpoint_write;

   // input register
   logic           s1_valid_ff, s1_valid_in;
   logic [31:0]    s1_time_ff;
   sensor_raw_type s1_heater_ff;
   sensor_raw_type s1_chamber_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff;
   logic [2:0]  rsp_user_ff;

   logic               req_accept;
   logic               advance;
   logic signed [15:0] heater_temp;
   logic signed [15:0] chamber_temp;
   logic               heater_ok;
   logic               chamber_ok;
   decision_type       dec;

   // csr port: always ready, write on the access phase
   assign csr_pready     = 1'b1;
   assign csr_write      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign setpoint_write = csr_write && (csr_paddr[4:2] == REG_SETPOINT);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[4:2])
            REG_SETPOINT:       cfg_in.setpoint       = csr_pwdata[11:0];
            REG_DWELL_MS:       cfg_in.dwell_ms       = csr_pwdata;
            REG_COOL_BAND:      cfg_in.cool_band      = csr_pwdata[7:0];
            REG_HEAT_BAND:      cfg_in.heat_band      = csr_pwdata[7:0];
            REG_HEATER_FAMILY:  cfg_in.heater_family  = csr_pwdata[7:0];
            REG_CHAMBER_FAMILY: cfg_in.chamber_family = csr_pwdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_SETPOINT:       csr_prdata = {{20{cfg_ff.setpoint[11]}}, cfg_ff.setpoint};
         REG_DWELL_MS:       csr_prdata = cfg_ff.dwell_ms;
         REG_COOL_BAND:      csr_prdata = {24'b0, cfg_ff.cool_band};
         REG_HEAT_BAND:      csr_prdata = {24'b0, cfg_ff.heat_band};
         REG_HEATER_FAMILY:  csr_prdata = {24'b0, cfg_ff.heater_family};
         REG_CHAMBER_FAMILY: csr_prdata = {24'b0, cfg_ff.chamber_family};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint       <= SETPOINT_RESET;
         cfg_ff.dwell_ms       <= DWELL_RESET;
         cfg_ff.cool_band      <= COOL_BAND_RESET;
         cfg_ff.heat_band      <= HEAT_BAND_RESET;
         cfg_ff.heater_family  <= FAMILY_RESET;
         cfg_ff.chamber_family <= FAMILY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // flow control: the input register moves on whenever the result register is empty or its word is taken
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_time_ff    <= req_tdata[31:0];
         s1_heater_ff  <= '{lsb:        req_tdata[39:32],
                            msb:        req_tdata[47:40],
                            res_cfg:    req_tdata[55:48],
                            remain:     req_tdata[63:56],
                            per_degree: req_tdata[71:64]};
         s1_chamber_ff <= '{lsb:        req_tdata[79:72],
                            msb:        req_tdata[87:80],
                            res_cfg:    req_tdata[95:88],
                            remain:     req_tdata[103:96],
                            per_degree: req_tdata[111:104]};
      end
      if (advance) begin
         rsp_data_ff <= {dec.since_switch_ms, chamber_temp, heater_temp};
         rsp_user_ff <= {dec.read_error, dec.cool_on, dec.heat_on};
      end
   end

   // one converter per sensor
   tcd_conv u_conv_heater (
      .family (cfg_ff.heater_family),
      .raw_in (s1_heater_ff),
      .temp   (heater_temp),
      .ok     (heater_ok)
   );

   tcd_conv u_conv_chamber (
      .family (cfg_ff.chamber_family),
      .raw_in (s1_chamber_ff),
      .temp   (chamber_temp),
      .ok     (chamber_ok)
   );

   // cooler dwell and heater decision, switch state moves once per word; a setpoint write re-arms the first decision
   tcd_ctrl #(
      .TIME_BITS (TIME_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .setpoint_write (setpoint_write),
      .cfg            (cfg_ff),
      .time_ms        (s1_time_ff),
      .heater_temp    (heater_temp),
      .chamber_temp   (chamber_temp),
      .heater_ok      (heater_ok),
      .chamber_ok     (chamber_ok),
      .dec            (dec)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted word lost from input register");

   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result register not loaded on advance");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff && $stable(s1_time_ff))
      else $error("stalled input register changed");
`endif

endmodule

`default_nettype wire
